@@ rtl/mlps_pkg.sv @@
// mlps_pkg: shared widths, item codes, datapath control struct and the sigmoid table
// for the two-layer perceptron block. No dependencies.

package mlps_pkg;

	// default network shape
	localparam int INPUT_NODES_DEF  = 8;
	localparam int HIDDEN_NODES_DEF = 8;
	localparam int OUTPUT_NODES_DEF = 4;
	localparam int MAX_RESULTS      = 4;

	// item field widths
	localparam int KIND_W = 2;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 3;
	localparam int VAL_W  = 16;
	localparam int IDX_W  = 2;
	localparam int ACT_W  = 13;

	// operand widths of the multiplier
	localparam int OPA_W  = 17;
	localparam int PROD_W = OPA_W + VAL_W;

	// one in Q1.12 and as a Q4.12 operand (bias row input)
	localparam logic [ACT_W-1:0]        ONE_Q12   = ACT_W'(4096);
	localparam logic signed [OPA_W-1:0] ONE_OPA   = OPA_W'(4096);

	typedef enum logic [KIND_W-1:0] {
		KIND_HIDDEN_WEIGHT = 2'd0,
		KIND_OUTPUT_WEIGHT = 2'd1,
		KIND_FEATURE       = 2'd2
	} kind_t;

	// control from the sequencer to the mac unit
	typedef struct packed {
		logic issue;   // operands valid this cycle
		logic clear;   // start a new node sum
	} mac_ctrl_t;

	// sigmoid table: entry k is the sigmoid at the midpoint of bin k, bins of 1/16 over [-8,8)
	typedef logic [255:0][ACT_W-1:0] sig_tab_t;

	localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

	function automatic sig_tab_t build_sig_table();
		sig_tab_t    tab;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] rem;
		logic [44:0] num;
		logic [44:0] quo;
		int          n;
		int          b;
		int          k;
		tab = '0;
		e   = 64'd1 << 32;
		for (n = 1; n <= 255; n++) begin
			e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
			if (n % 2 == 1) begin
				den = (64'd1 << 32) + e;
				num = 45'((64'd1 << 44) + (den >> 1));
				rem = '0;
				quo = '0;
				// rounded reciprocal by shift and subtract
				for (b = 44; b >= 0; b--) begin
					rem = {rem[62:0], num[b]};
					if (rem >= den) begin
						rem    = rem - den;
						quo[b] = 1'b1;
					end
				end
				k = 128 + (n - 1) / 2;
				tab[k] = quo[ACT_W-1:0];
			end
		end
		// lower half by symmetry
		for (k = 0; k < 128; k++) begin
			tab[k] = ONE_Q12 - tab[255-k];
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ rtl/mlps_in_if.sv @@
// mlps_in_if: input channel carrying weight writes and feature items.
// Depends on mlps_pkg for field widths.

interface mlps_in_if import mlps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [ROW_W-1:0]        row_index;
	logic [COL_W-1:0]        col_index;
	logic signed [VAL_W-1:0] value;
	logic                    last_feature;

	modport source (
		output valid, kind, row_index, col_index, value, last_feature,
		input  ready
	);

	modport sink (
		input  valid, kind, row_index, col_index, value, last_feature,
		output ready
	);
endinterface

@@ rtl/mlps_out_if.sv @@
// mlps_out_if: result channel carrying one output node activation per transfer.
// Depends on mlps_pkg for field widths.

interface mlps_out_if import mlps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] output_index;
	logic [ACT_W-1:0] activation;
	logic             last_output;

	modport source (
		output valid, output_index, activation, last_output,
		input  ready
	);

	modport sink (
		input  valid, output_index, activation, last_output,
		output ready
	);
endinterface

@@ rtl/mlps_mac.sv @@
// mlps_mac: registered multiplier, node accumulator and saturating sigmoid lookup.
// Depends on mlps_pkg (mac_ctrl_t, SIG_TABLE, operand widths).

module mlps_mac import mlps_pkg::*; #(
	parameter int ACC_W = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctrl_t               ctrl,
	input  logic signed [OPA_W-1:0] opa,
	input  logic signed [VAL_W-1:0] opw,
	output logic [ACT_W-1:0]        sig
);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     prod_vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-28:0]        acc_hi;
	logic                     in_range;
	logic [7:0]               sig_idx;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
		end else begin
			prod_vld_s2 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= opa * opw;
	end

	// node accumulator in Q.24
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// saturate to [-8,8) and pick the 1/16 bin
	assign acc_hi   = acc_q[ACC_W-1:27];
	assign in_range = (&acc_hi) | (~|acc_hi);

	always_comb begin
		if (in_range) begin
			sig_idx = {~acc_q[27], acc_q[26:20]};
		end else if (acc_q[ACC_W-1]) begin
			sig_idx = 8'd0;
		end else begin
			sig_idx = 8'd255;
		end
	end

	assign sig = SIG_TABLE[sig_idx];

endmodule

@@ rtl/mlp_sigmoid_inference.sv @@
// mlp_sigmoid_inference: top level of the two-layer perceptron forward pass, with the
// microcode sequencer, weight, feature and hidden activation memories.
// Depends on mlps_pkg, mlps_in_if, mlps_out_if and mlps_mac.

// Weight items (hidden or output layer, bias in the highest row) and feature items
// are taken one per cycle while the block is idle. A feature item marked last starts
// a pass that the microcode runs on a single multiply-accumulate unit: each node takes
// one setup step, one multiply-accumulate per source row plus one for the bias, two
// steps to empty the multiplier and one sigmoid step; a final step ends the pass. The
// sigmoid step of an output node waits while the result sink holds off a result.
// Results leave through an output register, one per output node for at most
// MAX_RESULTS (four) output nodes, the last one marked. No items are taken during a
// pass. Missing features of a short pattern count as zero; the feature count clears
// when the pass ends.

module mlp_sigmoid_inference import mlps_pkg::*; #(
	parameter int INPUT_NODES  = INPUT_NODES_DEF,
	parameter int HIDDEN_NODES = HIDDEN_NODES_DEF,
	parameter int OUTPUT_NODES = OUTPUT_NODES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mlps_in_if.sink   items,
	mlps_out_if.source results
);

	localparam int RES_CNT   = (OUTPUT_NODES < MAX_RESULTS) ? OUTPUT_NODES : MAX_RESULTS;
	localparam int MAX_ROWS  = (INPUT_NODES > HIDDEN_NODES) ? INPUT_NODES : HIDDEN_NODES;
	localparam int HW_DEPTH  = (INPUT_NODES + 1) * HIDDEN_NODES;
	localparam int OW_DEPTH  = (HIDDEN_NODES + 1) * OUTPUT_NODES;
	localparam int HW_AW     = $clog2(HW_DEPTH);
	localparam int OW_AW     = $clog2(OW_DEPTH);
	localparam int WA_W      = (HW_AW > OW_AW) ? HW_AW : OW_AW;
	localparam int ROWC_W    = $clog2(MAX_ROWS + 1);
	localparam int FB_AW     = (INPUT_NODES > 1) ? $clog2(INPUT_NODES) : 1;
	localparam int HA_AW     = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
	localparam int CNT_W     = $clog2(INPUT_NODES + 1);
	localparam int NODE_CAP0 = (HIDDEN_NODES > RES_CNT) ? HIDDEN_NODES : RES_CNT;
	localparam int NODE_CAP  = (NODE_CAP0 > 2) ? NODE_CAP0 : 2;
	localparam int NODE_W    = $clog2(NODE_CAP);
	localparam int ACC_W     = PROD_W - 2 + $clog2(MAX_ROWS + 2) + 1;

	// microcode
	localparam int STEP_W = 4;

	typedef enum logic [2:0] {
		C_NEXT  = 3'd0,
		C_JUMP  = 3'd1,
		C_START = 3'd2,
		C_ROWS  = 3'd3,
		C_NODES = 3'd4
	} cond_t;

	typedef struct packed {
		logic              wait_in;  // take items
		logic              setup;    // start a node: rows from zero, clear the sum
		logic              mac;      // issue one row
		logic              layer;    // 0 hidden, 1 output
		logic              act_hid;  // store hidden activation
		logic              act_out;  // load result register
		logic              done;     // end of pass
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_H_SETUP = 4'd1;
	localparam logic [STEP_W-1:0] STEP_H_MAC   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_H_DRN1  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_H_DRN2  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_H_ACT   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_O_SETUP = 4'd6;
	localparam logic [STEP_W-1:0] STEP_O_MAC   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_O_DRN1  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_O_DRN2  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_O_ACT   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_DONE    = 4'd11;

	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w        = '0;
		w.cond   = C_NEXT;
		w.target = STEP_IDLE;
		unique case (step)
			STEP_IDLE: begin
				w.wait_in = 1'b1;
				w.cond    = C_START;
			end
			STEP_H_SETUP: w.setup = 1'b1;
			STEP_H_MAC: begin
				w.mac  = 1'b1;
				w.cond = C_ROWS;
			end
			STEP_H_DRN1, STEP_H_DRN2: ;
			STEP_H_ACT: begin
				w.act_hid = 1'b1;
				w.cond    = C_NODES;
				w.target  = STEP_H_SETUP;
			end
			STEP_O_SETUP: begin
				w.setup = 1'b1;
				w.layer = 1'b1;
			end
			STEP_O_MAC: begin
				w.mac   = 1'b1;
				w.layer = 1'b1;
				w.cond  = C_ROWS;
			end
			STEP_O_DRN1, STEP_O_DRN2: w.layer = 1'b1;
			STEP_O_ACT: begin
				w.act_out = 1'b1;
				w.layer   = 1'b1;
				w.cond    = C_NODES;
				w.target  = STEP_O_SETUP;
			end
			STEP_DONE: begin
				w.done   = 1'b1;
				w.cond   = C_JUMP;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = C_JUMP;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	// sequencer state
	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;
	ctrl_word_t        cw;
	logic [NODE_W-1:0] node_q;
	logic [ROWC_W-1:0] row_q;
	logic [WA_W-1:0]   waddr_q;
	logic [CNT_W-1:0]  count_q;

	// memories
	logic signed [VAL_W-1:0] hw_mem [HW_DEPTH];
	logic signed [VAL_W-1:0] ow_mem [OW_DEPTH];
	logic signed [VAL_W-1:0] fb_mem [INPUT_NODES];
	logic [ACT_W-1:0]        ha_mem [HIDDEN_NODES];

	// operand fetch stage
	logic signed [VAL_W-1:0] hw_rd_s1;
	logic signed [VAL_W-1:0] ow_rd_s1;
	logic signed [VAL_W-1:0] fb_rd_s1;
	logic [ACT_W-1:0]        ha_rd_s1;
	logic                    issue_s1;
	logic                    layer_s1;
	logic                    bias_s1;
	logic                    zero_s1;

	// result register
	logic             out_vld_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [ACT_W-1:0] out_act_q;
	logic             out_last_q;

	logic                    take;
	logic                    start;
	logic                    hw_wr;
	logic                    ow_wr;
	logic                    fb_wr;
	logic [HW_AW-1:0]        hw_wa;
	logic [OW_AW-1:0]        ow_wa;
	logic                    row_last;
	logic                    node_last;
	logic                    out_busy;
	logic                    stall;
	logic [NODE_W+IDX_W-1:0] node_ext;
	logic signed [OPA_W-1:0] opa;
	logic signed [VAL_W-1:0] opw;
	logic [ACT_W-1:0]        sig;
	mac_ctrl_t               mac_ctrl;

	assign cw = ucode(pc_q);

	// item transfer decode
	assign take  = items.valid && items.ready;
	assign start = take && (items.kind == KIND_FEATURE) && items.last_feature;
	assign hw_wr = take && (items.kind == KIND_HIDDEN_WEIGHT)
		&& (int'(items.row_index) <= INPUT_NODES) && (int'(items.col_index) < HIDDEN_NODES);
	assign ow_wr = take && (items.kind == KIND_OUTPUT_WEIGHT)
		&& (int'(items.row_index) <= HIDDEN_NODES) && (int'(items.col_index) < OUTPUT_NODES);
	assign fb_wr = take && (items.kind == KIND_FEATURE) && (int'(count_q) < INPUT_NODES);
	assign hw_wa = HW_AW'(int'(items.row_index) * HIDDEN_NODES + int'(items.col_index));
	assign ow_wa = OW_AW'(int'(items.row_index) * OUTPUT_NODES + int'(items.col_index));

	assign items.ready = cw.wait_in;

	// loop conditions
	assign row_last  = int'(row_q) == (cw.layer ? HIDDEN_NODES : INPUT_NODES);
	assign node_last = int'(node_q) == (cw.layer ? RES_CNT - 1 : HIDDEN_NODES - 1);
	assign out_busy  = out_vld_q && !results.ready;
	assign stall     = cw.act_out && out_busy;

	// next step
	always_comb begin
		pc_d = pc_q;
		unique case (cw.cond)
			C_NEXT:  pc_d = pc_q + STEP_W'(1);
			C_JUMP:  pc_d = cw.target;
			C_START: pc_d = start ? pc_q + STEP_W'(1) : pc_q;
			C_ROWS:  pc_d = row_last ? pc_q + STEP_W'(1) : pc_q;
			C_NODES: begin
				if (stall) begin
					pc_d = pc_q;
				end else if (node_last) begin
					pc_d = pc_q + STEP_W'(1);
				end else begin
					pc_d = cw.target;
				end
			end
			default: pc_d = STEP_IDLE;
		endcase
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= STEP_IDLE;
			node_q  <= '0;
			row_q   <= '0;
			waddr_q <= '0;
			count_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (cw.setup) begin
				row_q   <= '0;
				waddr_q <= WA_W'(node_q);
			end else if (cw.mac) begin
				row_q   <= row_q + ROWC_W'(1);
				waddr_q <= waddr_q + WA_W'(cw.layer ? OUTPUT_NODES : HIDDEN_NODES);
			end
			if (cw.cond == C_NODES && !stall) begin
				node_q <= node_last ? '0 : node_q + NODE_W'(1);
			end
			if (cw.done) begin
				count_q <= '0;
			end else if (fb_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (hw_wr) begin
			hw_mem[hw_wa] <= items.value;
		end
		if (ow_wr) begin
			ow_mem[ow_wa] <= items.value;
		end
		if (fb_wr) begin
			fb_mem[count_q[FB_AW-1:0]] <= items.value;
		end
		if (cw.act_hid) begin
			ha_mem[node_q[HA_AW-1:0]] <= sig;
		end
	end

	// operand reads, registered
	always_ff @(posedge clk) begin
		if (cw.mac && !cw.layer) begin
			hw_rd_s1 <= hw_mem[waddr_q[HW_AW-1:0]];
		end
		if (cw.mac && cw.layer) begin
			ow_rd_s1 <= ow_mem[waddr_q[OW_AW-1:0]];
		end
		if (cw.mac && !cw.layer && int'(row_q) < INPUT_NODES) begin
			fb_rd_s1 <= fb_mem[row_q[FB_AW-1:0]];
		end
		if (cw.mac && cw.layer && int'(row_q) < HIDDEN_NODES) begin
			ha_rd_s1 <= ha_mem[row_q[HA_AW-1:0]];
		end
		layer_s1 <= cw.layer;
		bias_s1  <= row_last;
		zero_s1  <= int'(row_q) >= int'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cw.mac;
		end
	end

	// operand select: bias row takes one, unfilled features read as zero
	always_comb begin
		if (bias_s1) begin
			opa = ONE_OPA;
		end else if (layer_s1) begin
			opa = OPA_W'(ha_rd_s1);
		end else if (zero_s1) begin
			opa = '0;
		end else begin
			opa = OPA_W'(fb_rd_s1);
		end
	end

	assign opw = layer_s1 ? ow_rd_s1 : hw_rd_s1;

	assign mac_ctrl.issue = issue_s1;
	assign mac_ctrl.clear = cw.setup;

	mlps_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.opa    (opa),
		.opw    (opw),
		.sig    (sig)
	);

	// result register
	assign node_ext = {{IDX_W{1'b0}}, node_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cw.act_out && !out_busy) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.act_out && !out_busy) begin
			out_idx_q  <= node_ext[IDX_W-1:0];
			out_act_q  <= sig;
			out_last_q <= node_last;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.output_index = out_idx_q;
	assign results.activation   = out_act_q;
	assign results.last_output  = out_last_q;

endmodule

@@ rtl/mlps_checker.sv @@
// mlps_checker: port-level checks on the perceptron block, bound to the top level.
// Depends on mlps_pkg and mlp_sigmoid_inference.

module mlps_checker import mlps_pkg::*; #(
	parameter int OUTPUT_NODES = OUTPUT_NODES_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [KIND_W-1:0] in_kind,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [IDX_W-1:0]  out_index,
	input logic [ACT_W-1:0]  out_activation,
	input logic              out_last
);

	localparam int RES_CNT = (OUTPUT_NODES < MAX_RESULTS) ? OUTPUT_NODES : MAX_RESULTS;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index)
			&& $stable(out_activation) && $stable(out_last))
		else $error("result changed while stalled");

	// a pass start stops further input transfers
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == KIND_FEATURE && in_last |=> !in_ready)
		else $error("input taken after a pass started");

	// activation never exceeds one
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_activation <= ONE_Q12)
		else $error("activation above one");

	// last mark sits on the final output node
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_index == IDX_W'(RES_CNT - 1))
		else $error("last mark on wrong output node");

endmodule

bind mlp_sigmoid_inference mlps_checker #(
	.OUTPUT_NODES (OUTPUT_NODES)
) u_mlps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (items.valid),
	.in_ready       (items.ready),
	.in_kind        (items.kind),
	.in_last        (items.last_feature),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_index      (results.output_index),
	.out_activation (results.activation),
	.out_last       (results.last_output)
);
